[hdl/assert_macros.svh]
// Assertion macros for the checker module of the rotary pair rotator.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rpr_pkg.sv]
// Package of the rotary pair rotator: widths, codes, payload types and the
// arctangent table of the CORDIC. No dependencies.
package rpr_pkg;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_DEPTH);
  localparam int unsigned MAX_POSITIONS = 65536;
  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned XW            = 44;
  localparam int unsigned ZW            = 34;

  localparam logic [15:0] POS_MASK =
    (MAX_POSITIONS >= 65536) ? 16'hFFFF : 16'(MAX_POSITIONS - 1);
  localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ROTATE = 1'b1;

  typedef enum logic [1:0] {
    QUAD_0, QUAD_90, QUAD_180, QUAD_270
  } rpr_quad_t;

  typedef struct packed {
    logic                 op;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rpr_rot_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h2000_0000;
      5'd1:  val = 32'h12E4_051E;
      5'd2:  val = 32'h09FB_385B;
      5'd3:  val = 32'h0511_11D4;
      5'd4:  val = 32'h028B_0D43;
      5'd5:  val = 32'h0145_D7E1;
      5'd6:  val = 32'h00A2_F61E;
      5'd7:  val = 32'h0051_7C55;
      5'd8:  val = 32'h0028_BE53;
      5'd9:  val = 32'h0014_5F2F;
      5'd10: val = 32'h000A_2F98;
      5'd11: val = 32'h0005_17CC;
      5'd12: val = 32'h0002_8BE6;
      5'd13: val = 32'h0001_45F3;
      5'd14: val = 32'h0000_A2FA;
      5'd15: val = 32'h0000_517D;
      5'd16: val = 32'h0000_28BE;
      5'd17: val = 32'h0000_145F;
      5'd18: val = 32'h0000_0A30;
      5'd19: val = 32'h0000_0518;
      5'd20: val = 32'h0000_028C;
      5'd21: val = 32'h0000_0146;
      5'd22: val = 32'h0000_00A3;
      5'd23: val = 32'h0000_0051;
      5'd24: val = 32'h0000_0029;
      5'd25: val = 32'h0000_0014;
      5'd26: val = 32'h0000_000A;
      5'd27: val = 32'h0000_0005;
      5'd28: val = 32'h0000_0003;
      5'd29: val = 32'h0000_0001;
      5'd30: val = 32'h0000_0001;
      5'd31: val = 32'h0000_0000;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

[hdl/rpr_front.sv]
// Front end of the rotary pair rotator: frequency table, angle and gain
// multipliers, and the exact quarter-turn step. Depends on rpr_pkg.
module rpr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [rpr_pkg::IDX_W-1:0]   in_idx,
  input  logic [31:0]                 in_freq,
  input  logic [15:0]                 in_pos,
  input  logic signed [31:0]          in_a,
  input  logic signed [31:0]          in_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rpr_pkg::rpr_rot_t           out_data
);
  import rpr_pkg::*;

  logic [31:0] mem [TABLE_DEPTH];

  logic               v1_r, v2_r, v3_r;
  logic               rdy1, rdy2, rdy3;
  logic               op1_r, op2_r;
  logic [31:0]        freq1_r;
  logic [15:0]        pos1_r;
  logic signed [31:0] a1_r, b1_r;
  logic [31:0]        angle2_r;
  logic signed [63:0] pa2_r, pb2_r;
  rpr_rot_t           rot3_r;

  logic [31:0]          angle_nxt;
  logic signed [63:0]   pa_nxt, pb_nxt;
  logic signed [32:0]   a_ext, b_ext, k_ext;
  logic signed [63:0]   pa_rnd, pb_rnd;
  logic signed [XW-1:0] x0, y0;
  logic [31:0]          qsum, resid;
  rpr_quad_t            quad;
  rpr_rot_t             rot_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      if (in_op == OP_LOAD) begin
        mem[in_idx] <= in_freq;
      end
      freq1_r <= mem[in_idx];
      op1_r   <= in_op;
      pos1_r  <= in_pos & POS_MASK;
      a1_r    <= in_a;
      b1_r    <= in_b;
    end
  end

  assign a_ext     = {a1_r[31], a1_r};
  assign b_ext     = {b1_r[31], b1_r};
  assign k_ext     = {1'b0, GAIN_Q32};
  assign angle_nxt = 32'({16'h0000, pos1_r} * {32'h0000_0000, freq1_r});
  assign pa_nxt    = a_ext * k_ext;
  assign pb_nxt    = b_ext * k_ext;

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      op2_r    <= op1_r;
      angle2_r <= angle_nxt;
      pa2_r    <= pa_nxt;
      pb2_r    <= pb_nxt;
    end
  end

  assign pa_rnd = pa2_r + 64'sd8388608;
  assign pb_rnd = pb2_r + 64'sd8388608;
  assign x0     = XW'($signed(pa_rnd[63:24]));
  assign y0     = XW'($signed(pb_rnd[63:24]));
  assign qsum   = angle2_r + 32'h2000_0000;
  assign quad   = rpr_quad_t'(qsum[31:30]);
  assign resid  = angle2_r - {qsum[31:30], 30'd0};

  always_comb begin
    rot_nxt.op = op2_r;
    rot_nxt.z  = ZW'($signed(resid));
    unique case (quad)
      QUAD_0: begin
        rot_nxt.x = x0;
        rot_nxt.y = y0;
      end
      QUAD_90: begin
        rot_nxt.x = -y0;
        rot_nxt.y = x0;
      end
      QUAD_180: begin
        rot_nxt.x = -x0;
        rot_nxt.y = -y0;
      end
      QUAD_270: begin
        rot_nxt.x = y0;
        rot_nxt.y = -x0;
      end
      default: begin
        rot_nxt.x = x0;
        rot_nxt.y = y0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      rot3_r <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign out_valid = v3_r;
  assign out_data  = rot3_r;

endmodule

[hdl/rpr_cordic.sv]
// Pipelined CORDIC of the rotary pair rotator, one micro-rotation per
// register stage. Depends on rpr_pkg.
module rpr_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpr_pkg::rpr_rot_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rpr_pkg::rpr_rot_t   out_data
);
  import rpr_pkg::*;

  logic     vld_r [CORDIC_STAGES];
  rpr_rot_t dat_r [CORDIC_STAGES];
  logic     src_vld [CORDIC_STAGES+1];
  rpr_rot_t src_dat [CORDIC_STAGES+1];
  logic     rdy [CORDIC_STAGES+1];

  assign src_vld[0]         = in_valid;
  assign src_dat[0]         = in_data;
  assign rdy[CORDIC_STAGES] = out_ready;
  assign in_ready           = rdy[0];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    rpr_rot_t             cur;
    rpr_rot_t             stg_nxt;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;

    assign cur = src_dat[k];
    assign dx  = cur.y >>> k;
    assign dy  = cur.x >>> k;
    assign ang = $signed(ZW'(atan_turn(5'(k))));

    always_comb begin
      stg_nxt.op = cur.op;
      if (cur.z >= 0) begin
        stg_nxt.x = cur.x - dx;
        stg_nxt.y = cur.y + dy;
        stg_nxt.z = cur.z - ang;
      end else begin
        stg_nxt.x = cur.x + dx;
        stg_nxt.y = cur.y - dy;
        stg_nxt.z = cur.z + ang;
      end
    end

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_vld[k]) begin
        dat_r[k] <= stg_nxt;
      end
    end

    assign src_vld[k+1] = vld_r[k];
    assign src_dat[k+1] = dat_r[k];
  end

  assign out_valid = src_vld[CORDIC_STAGES];
  assign out_data  = src_dat[CORDIC_STAGES];

endmodule

[hdl/rpr_output.sv]
// Output stage of the rotary pair rotator: rounding to Q16.16, saturation
// and the result register. Depends on rpr_pkg.
module rpr_output (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpr_pkg::rpr_rot_t   in_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [63:0]         out_tdata,
  output logic                out_tuser
);
  import rpr_pkg::*;

  logic                 valid_r;
  logic [31:0]          first_r, second_r;
  logic                 clip_r;
  logic signed [XW-1:0] xr, yr;
  logic [31:0]          first_nxt, second_nxt;
  logic                 clip_x, clip_y;

  function automatic logic [31:0] sat32(input logic signed [XW-1:0] v, output logic clip);
    logic [XW-9:0] t;
    t    = v[XW-1:8];
    clip = (t[XW-9:31] != {(XW-39){t[31]}});
    if (!clip) begin
      return t[31:0];
    end
    return t[XW-9] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  assign xr       = in_data.x + XW'(128);
  assign yr       = in_data.y + XW'(128);
  assign in_ready = !valid_r || out_tready;

  always_comb begin
    first_nxt  = sat32(xr, clip_x);
    second_nxt = sat32(yr, clip_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      if (in_data.op == OP_ROTATE) begin
        first_r  <= first_nxt;
        second_r <= second_nxt;
        clip_r   <= clip_x || clip_y;
      end else begin
        first_r  <= 32'h0000_0000;
        second_r <= 32'h0000_0000;
        clip_r   <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {second_r, first_r};
  assign out_tuser  = clip_r;

endmodule

[hdl/rotary_position_rotate_pair.sv]
// Rotary position embedding on one element pair per transaction.
// Throughput: one transaction per cycle; each pipeline stage holds while stalled.
// Reset (synchronous, active low) clears all valid bits; the frequency table
// is not cleared and must be loaded before use.
module rotary_position_rotate_pair (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pair_index[5:0], frequency[37:6], position[53:38], first_in[85:54],
  // second_in[117:86], zero padding[119:118]
  input  logic [119:0] in_tdata,
  // operation[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // first_out[31:0], second_out[63:32]
  output logic [63:0]  out_tdata,
  // clipped[0]
  output logic         out_tuser
);
  import rpr_pkg::*;

  logic     fe_valid, fe_ready;
  rpr_rot_t fe_data;
  logic     cd_valid, cd_ready;
  rpr_rot_t cd_data;

  rpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_idx    (in_tdata[IDX_W-1:0]),
    .in_freq   (in_tdata[37:6]),
    .in_pos    (in_tdata[53:38]),
    .in_a      ($signed(in_tdata[85:54])),
    .in_b      ($signed(in_tdata[117:86])),
    .out_valid (fe_valid),
    .out_ready (fe_ready),
    .out_data  (fe_data)
  );

  rpr_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_data   (fe_data),
    .out_valid (cd_valid),
    .out_ready (cd_ready),
    .out_data  (cd_data)
  );

  rpr_output u_output (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cd_valid),
    .in_ready   (cd_ready),
    .in_data    (cd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[hdl/rpr_checker.sv]
// Port-level checker for the rotary pair rotator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  `RPR_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `RPR_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `RPR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result present after reset")
  `RPR_ASSERT(a_clip_value, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[31:0] == 32'h7FFF_FFFF || out_tdata[31:0] == 32'h8000_0000 || out_tdata[63:32] == 32'h7FFF_FFFF || out_tdata[63:32] == 32'h8000_0000, "clip flag without a saturated value")

endmodule

bind rotary_position_rotate_pair rpr_checker u_rpr_checker (.*);

[sim/rotary_position_rotate_pair_tb.sv]
// Testbench of rotary_position_rotate_pair: loads the frequency table, rotates pairs with
// directed and random transactions, and checks every result against its own predictor.
// Depends on rpr_pkg and the rotary_position_rotate_pair RTL only.
`timescale 1ns / 100ps

module rotary_position_rotate_pair_tb;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    logic        clip;
  } rotation_t;

  localparam longint GainQ32 = 64'h0000_0000_9B74_EDA8;
  localparam logic [31:0] ArcTurns [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };
  localparam logic [31:0] MaxQ16 = 32'h7FFF_FFFF;
  localparam logic [31:0] MinQ16 = 32'h8000_0000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tuser;

  logic [31:0]  turn_rate [rpr_pkg::TABLE_DEPTH];
  bit           rate_loaded [rpr_pkg::TABLE_DEPTH];
  rotation_t    pending_rotations [$];

  bit tx_idle;
  bit rx_idle;
  int rx_wait;
  int rx_hold;
  int mismatch_count;
  int loads_sent;
  int rotations_sent;
  int clipped_seen;
  int results_seen;

  rotary_position_rotate_pair u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [31:0] saturate_q16(input longint v, inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return MaxQ16;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return MinQ16;
    end
    return v[31:0];
  endfunction

  function automatic rotation_t predict_rotation(input logic [31:0] rate,
                                                 input logic [15:0] pos,
                                                 input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    rotation_t res;
    logic [63:0] product;
    logic [31:0] angle;
    logic [31:0] resid;
    logic [32:0] rounded;
    rpr_pkg::rpr_quad_t quad;
    int resid_s;
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    product = 64'(pos) * 64'(rate);
    angle = product[31:0];
    x = (longint'(a) * GainQ32 + (64'sd1 <<< 23)) >>> 24;
    y = (longint'(b) * GainQ32 + (64'sd1 <<< 23)) >>> 24;
    rounded = 33'(angle) + 33'h0_2000_0000;
    quad = rpr_pkg::rpr_quad_t'(rounded[31:30]);
    resid = angle - {rounded[31:30], 30'd0};
    resid_s = resid;
    z = resid_s;
    case (quad)
      rpr_pkg::QUAD_90: begin
        t = x;
        x = -y;
        y = t;
      end
      rpr_pkg::QUAD_180: begin
        x = -x;
        y = -y;
      end
      rpr_pkg::QUAD_270: begin
        t = x;
        x = y;
        y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < rpr_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ArcTurns[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ArcTurns[i]);
      end
    end
    res.clip = 1'b0;
    res.first = saturate_q16((x + 128) >>> 8, res.clip);
    res.second = saturate_q16((y + 128) >>> 8, res.clip);
    return res;
  endfunction

  task automatic send_item(input logic op, input logic [5:0] idx, input logic [31:0] rate,
                           input logic [15:0] pos, input logic [31:0] a,
                           input logic [31:0] b);
    int gap;
    rotation_t want;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, b, a, pos, rate, idx};
    do @(posedge clk); while (!in_tready);
    if (op == rpr_pkg::OP_LOAD) begin
      turn_rate[idx] = rate;
      rate_loaded[idx] = 1'b1;
      want = '{32'd0, 32'd0, 1'b0};
      loads_sent++;
    end else begin
      want = predict_rotation(turn_rate[idx], pos, a, b);
      rotations_sent++;
    end
    pending_rotations.push_back(want);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rotations.size() > 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_q16();
    case ($urandom_range(0, 9))
      0: return MaxQ16;
      1: return MinQ16;
      2: return 32'd0;
      3: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    logic [5:0] idx;
    if ($urandom_range(0, 4) == 0) begin
      send_item(rpr_pkg::OP_LOAD, $urandom_range(0, 63), $urandom, $urandom, $urandom,
                $urandom);
    end else begin
      do idx = $urandom_range(0, 63); while (!rate_loaded[idx]);
      send_item(rpr_pkg::OP_ROTATE, idx, $urandom, $urandom, random_q16(), random_q16());
    end
  endtask

  task automatic test_table_load();
    logic [31:0] rates [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h2000_0000, 32'h1FFF_FFFF,
                               32'h4000_0000, 32'h6000_0000, 32'h8000_0000, 32'hE000_0000};
    for (int i = 0; i < 8; i++) begin
      send_item(rpr_pkg::OP_LOAD, 6'(i), rates[i], $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_rotate_extremes();
    send_item(rpr_pkg::OP_ROTATE, 6'd0, $urandom, 16'hFFFF, MaxQ16, MinQ16);
    send_item(rpr_pkg::OP_ROTATE, 6'd1, $urandom, 16'd1, 32'h0001_0000, 32'd0);
    send_item(rpr_pkg::OP_ROTATE, 6'd2, $urandom, 16'd1, MaxQ16, MaxQ16);
    send_item(rpr_pkg::OP_ROTATE, 6'd3, $urandom, 16'd1, MinQ16, MinQ16);
    send_item(rpr_pkg::OP_ROTATE, 6'd4, $urandom, 16'd1, 32'h1234_5678, 32'hEDCB_A988);
    send_item(rpr_pkg::OP_ROTATE, 6'd5, $urandom, 16'd1, 32'h0001_0000, 32'd0);
    send_item(rpr_pkg::OP_ROTATE, 6'd6, $urandom, 16'd1, MinQ16, 32'd0);
    send_item(rpr_pkg::OP_ROTATE, 6'd7, $urandom, 16'hFFFF, 32'hFFFF_0000, 32'h0000_8000);
    send_item(rpr_pkg::OP_ROTATE, 6'd1, $urandom, 16'hFFFF, 32'd0, 32'd0);
    send_item(rpr_pkg::OP_ROTATE, 6'd6, $urandom, 16'd0, MaxQ16, MinQ16);
  endtask

  task automatic test_random_stream(input int count, input bit sender_idles,
                                    input bit receiver_idles);
    tx_idle = sender_idles;
    rx_idle = receiver_idles;
    repeat (count) send_random_item();
  endtask

  task automatic test_backpressure();
    wait_drained();
    tx_idle = 1'b0;
    rx_hold = 150;
    repeat (60) send_random_item();
    wait_drained();
  endtask

  always @(posedge clk) begin
    rotation_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
      results_seen++;
      if (out_tuser) clipped_seen++;
      if (pending_rotations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transaction: first %0d second %0d clipped %0b",
                   $signed(out_tdata[31:0]), $signed(out_tdata[63:32]), out_tuser);
        end
      end else begin
        want = pending_rotations.pop_front();
        if (out_tdata[31:0] !== want.first || out_tdata[63:32] !== want.second ||
            out_tuser !== want.clip) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: first %0d/%0d second %0d/%0d clipped %0b/%0b (exp/act)",
                     $signed(want.first), $signed(out_tdata[31:0]),
                     $signed(want.second), $signed(out_tdata[63:32]),
                     want.clip, out_tuser);
          end
        end
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_wait = 0;
    rx_hold = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_table_load();
    test_rotate_extremes();
    test_random_stream(400, 1'b1, 1'b1);
    test_backpressure();
    test_random_stream(300, 1'b0, 1'b0);
    test_random_stream(300, 1'b1, 1'b0);
    wait_drained();
    test_random_stream(270, 1'b0, 1'b1);

    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_rotations.size() > 0) begin
      $display("%0d results never arrived", pending_rotations.size());
      mismatch_count += pending_rotations.size();
    end
    $display("Sent %0d table loads and %0d rotations; %0d results checked, %0d clipped.",
             loads_sent, rotations_sent, results_seen, clipped_seen);
    $display("Mismatches: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
